// File: hw/rtl/tcf_pkg.sv
// Shared types, constants and the CORDIC angle table for the tilt complementary filter.
`default_nettype none

package tcf_pkg;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_SQRT,
    ST_CORDIC,
    ST_ROUND,
    ST_GYRO,
    ST_DIVIDE,
    ST_PRED,
    ST_BLEND,
    ST_FINISH
  } state_t;

  // Datapath step enables decoded from the state.
  typedef struct packed {
    logic load;
    logic square;
    logic sqrt_step;
    logic cordic_step;
    logic round;
    logic gyro;
    logic div_step;
    logic pred;
    logic blend_step;
    logic finish;
  } ctrl_t;

  // Configuration register indexes.
  localparam logic [2:0] REG_GYRO_WEIGHT   = 3'd0;
  localparam logic [2:0] REG_ACCEL_WEIGHT  = 3'd1;
  localparam logic [2:0] REG_RATE_OFFSET_X = 3'd2;
  localparam logic [2:0] REG_RATE_OFFSET_Y = 3'd3;
  localparam logic [2:0] REG_RATE_OFFSET_Z = 3'd4;

  localparam int SAMPLE_W    = 16;
  localparam int ANGLE_W     = 24;
  localparam int ACC_ANGLE_W = 16;
  localparam int WEIGHT_W    = 16;
  localparam int SQRT_STEPS  = 32;
  localparam int ATAN_LEN    = 24;
  localparam int ATAN_W      = 22;

  // Counts per (deg/s) times 1000 ms per second.
  localparam logic [16:0] GYRO_DIV      = 17'd65500;
  localparam int          GYRO_DIV_HALF = 32750;

  // atan(2^-i) in degrees, Q16, rounded to nearest.
  function automatic logic [ATAN_W-1:0] atan_deg(input logic [4:0] i);
    logic [ATAN_W-1:0] r;
    case (i)
      5'd0:    r = 22'd2949120;
      5'd1:    r = 22'd1740967;
      5'd2:    r = 22'd919879;
      5'd3:    r = 22'd466945;
      5'd4:    r = 22'd234379;
      5'd5:    r = 22'd117304;
      5'd6:    r = 22'd58666;
      5'd7:    r = 22'd29335;
      5'd8:    r = 22'd14668;
      5'd9:    r = 22'd7334;
      5'd10:   r = 22'd3667;
      5'd11:   r = 22'd1833;
      5'd12:   r = 22'd917;
      5'd13:   r = 22'd458;
      5'd14:   r = 22'd229;
      5'd15:   r = 22'd115;
      5'd16:   r = 22'd57;
      5'd17:   r = 22'd29;
      5'd18:   r = 22'd14;
      5'd19:   r = 22'd7;
      5'd20:   r = 22'd4;
      5'd21:   r = 22'd2;
      5'd22:   r = 22'd1;
      default: r = 22'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/tilt_complementary_filter.sv
// Top level of the tilt complementary filter: sequencer and digit-serial datapath.
`default_nettype none

// One item is worked on at a time. An accepted sample goes through these steps in order
// before its result is offered on the master side: a step that sums the squares, a
// two-bit-per-cycle square root, CORDIC vectoring (both tilt axes run side by side), a
// rounding step, a step that forms the gyro products, a bit-serial divider for the gyro
// integration (three axes side by side), a step that loads the weight multiply, a
// bit-serial weight multiply for the blend, and a step that writes the output register.
// The sequencer then returns to its idle state, and only there takes the next sample.
// The last step waits while the previous result has not been taken. The result sits in
// an output register, so the sequencer returns to idle and takes the next sample while
// the last result still waits. Configuration writes are taken in any cycle and should
// only be issued while the filter is idle.
module tilt_complementary_filter #(
  parameter int ANGLE_FRAC_BITS  = 8,
  parameter int CORDIC_STEPS     = 16,
  parameter int WEIGHT_FRAC_BITS = 15
) (
  input  wire logic         clk,
  input  wire logic         rst,
  // Sample input.
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // accel_x, accel_y, accel_z, rate_x, rate_y, rate_z, elapsed_ms (16 bits each)
  input  wire logic [111:0] s_tdata,
  // seed
  input  wire logic         s_tuser,
  // Result output.
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // angle_x, angle_y, angle_z (24 bits each), accel_angle_x, accel_angle_y (16 bits each)
  output logic [103:0]      m_tdata,
  // Configuration write channel.
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [15:0]  cfg_data
);
  import tcf_pkg::*;

  localparam int SH    = 16 - ANGLE_FRAC_BITS;
  localparam int DW    = 34 + ANGLE_FRAC_BITS;
  localparam int DQ    = 20 + ANGLE_FRAC_BITS;
  localparam int PW    = ((DQ > ANGLE_W) ? DQ : ANGLE_W) + 1;
  localparam int BW    = PW + 18;
  localparam int CNT_W = $clog2(DW);
  localparam int XW    = 36;
  localparam int ZW    = 25;

  localparam logic signed [BW-1:0] MAX_A = BW'(8388607);
  localparam logic signed [BW-1:0] MIN_A = -MAX_A - BW'(1);
  localparam logic signed [ZW:0]   MAX_C = (ZW+1)'(32767);
  localparam logic signed [ZW:0]   MIN_C = -MAX_C - (ZW+1)'(1);

  state_t state, state_next;
  ctrl_t  ctrl;
  logic [CNT_W-1:0] cnt;

  // Configuration registers.
  logic [WEIGHT_W-1:0]        gyro_weight, accel_weight;
  logic signed [SAMPLE_W-1:0] rate_offset [3];

  // Captured sample.
  logic signed [SAMPLE_W-1:0] accel [3];
  logic signed [SAMPLE_W-1:0] rate [3];
  logic [SAMPLE_W-1:0]        elapsed_ms;
  logic                       seed;

  // Tilt lanes: index 0 is X, index 1 is Y.
  logic [63:0]               rad [2];
  logic [35:0]               rem [2];
  logic [31:0]               root [2];
  logic signed [XW-1:0]      cx [2];
  logic signed [XW-1:0]      cy [2];
  logic signed [ZW-1:0]      cz [2];
  logic signed [ACC_ANGLE_W-1:0] acc_angle [2];

  // Gyro lanes: X, Y, Z.
  logic          neg [3];
  logic [DW-1:0] dvd [3];
  logic [16:0]   drem [3];
  logic [DW-1:0] quo [3];

  // Blend lanes.
  logic signed [BW-1:0] psh [2];
  logic signed [BW-1:0] ash [2];
  logic signed [BW-1:0] bacc [2];
  logic [WEIGHT_W-1:0]  wg, wa;

  // Filter state.
  logic signed [ANGLE_W-1:0] tilt [3];

  logic [103:0] out_data;

  // Combinational per-lane values.
  logic signed [SAMPLE_W-1:0] num_in [2];
  logic signed [SAMPLE_W-1:0] b_in [2];
  logic [35:0]                rem_sh [2];
  logic [35:0]                trial [2];
  logic                       sq_ge [2];
  logic [31:0]                root_next [2];
  logic [35:0]                rem_next [2];
  logic signed [DQ-1:0]       dstep [3];
  logic signed [PW-1:0]       pred [3];
  logic [16:0]                div_sh [3];
  logic                       div_ge [3];
  logic signed [ZW:0]         ang_r [2];
  logic signed [ZW:0]         ang_s [2];
  logic signed [ACC_ANGLE_W-1:0] ang_sat [2];
  logic signed [BW-1:0]       blend_r [2];
  logic signed [ANGLE_W-1:0]  blend_sat [2];
  logic signed [ANGLE_W-1:0]  head_sat;
  logic signed [BW-1:0]       head_w;

  assign cfg_ready = 1'b1;
  assign m_tdata   = out_data;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (s_tvalid) state_next = ST_SQUARE;
      ST_SQUARE: state_next = ST_SQRT;
      ST_SQRT:   if (cnt == CNT_W'(SQRT_STEPS - 1)) state_next = ST_CORDIC;
      ST_CORDIC: if (cnt == CNT_W'(CORDIC_STEPS - 1)) state_next = ST_ROUND;
      ST_ROUND:  state_next = ST_GYRO;
      ST_GYRO:   state_next = ST_DIVIDE;
      ST_DIVIDE: if (cnt == CNT_W'(DW - 1)) state_next = ST_PRED;
      ST_PRED:   state_next = ST_BLEND;
      ST_BLEND:  if (cnt == CNT_W'(WEIGHT_W - 1)) state_next = ST_FINISH;
      ST_FINISH: if (!m_tvalid || m_tready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Step enables.
  always_comb begin
    ctrl     = '0;
    s_tready = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready  = 1'b1;
        ctrl.load = s_tvalid;
      end
      ST_SQUARE: ctrl.square      = 1'b1;
      ST_SQRT:   ctrl.sqrt_step   = 1'b1;
      ST_CORDIC: ctrl.cordic_step = 1'b1;
      ST_ROUND:  ctrl.round       = 1'b1;
      ST_GYRO:   ctrl.gyro        = 1'b1;
      ST_DIVIDE: ctrl.div_step    = 1'b1;
      ST_PRED:   ctrl.pred        = 1'b1;
      ST_BLEND:  ctrl.blend_step  = 1'b1;
      ST_FINISH: ctrl.finish      = !m_tvalid || m_tready;
      default:   ctrl = '0;
    endcase
  end

  // Lane wiring and per-digit arithmetic.
  always_comb begin
    num_in[0] = accel[1];
    b_in[0]   = accel[0];
    num_in[1] = accel[0];
    b_in[1]   = accel[1];
    for (int l = 0; l < 2; l++) begin
      rem_sh[l]    = {rem[l][33:0], rad[l][63:62]};
      trial[l]     = {2'b00, root[l], 2'b01};
      sq_ge[l]     = rem_sh[l] >= trial[l];
      rem_next[l]  = sq_ge[l] ? rem_sh[l] - trial[l] : rem_sh[l];
      root_next[l] = {root[l][30:0], sq_ge[l]};
      // Round the Q16 degree angle to the output scale, negate it for lane 1 and saturate.
      ang_r[l] = ($signed({cz[l][ZW-1], cz[l]}) + (ZW+1)'(1 << (SH - 1))) >>> SH;
      ang_s[l] = (l == 1) ? -ang_r[l] : ang_r[l];
      if (ang_s[l] > MAX_C) begin
        ang_sat[l] = ACC_ANGLE_W'(32767);
      end else if (ang_s[l] < MIN_C) begin
        ang_sat[l] = -ACC_ANGLE_W'(32767) - ACC_ANGLE_W'(1);
      end else begin
        ang_sat[l] = ang_s[l][ACC_ANGLE_W-1:0];
      end
      // Round the blend sum and saturate.
      blend_r[l] = (bacc[l] + BW'(1 << (WEIGHT_FRAC_BITS - 1))) >>> WEIGHT_FRAC_BITS;
      if (blend_r[l] > MAX_A) begin
        blend_sat[l] = ANGLE_W'(8388607);
      end else if (blend_r[l] < MIN_A) begin
        blend_sat[l] = -ANGLE_W'(8388607) - ANGLE_W'(1);
      end else begin
        blend_sat[l] = blend_r[l][ANGLE_W-1:0];
      end
    end
    for (int g = 0; g < 3; g++) begin
      div_sh[g] = {drem[g][15:0], dvd[g][DW-1]};
      div_ge[g] = div_sh[g] >= GYRO_DIV;
      dstep[g]  = neg[g] ? -$signed({1'b0, quo[g][DQ-2:0]}) : $signed({1'b0, quo[g][DQ-2:0]});
      pred[g]   = PW'(tilt[g]) + PW'(dstep[g]);
    end
    head_w = BW'(pred[2]);
    if (head_w > MAX_A) begin
      head_sat = ANGLE_W'(8388607);
    end else if (head_w < MIN_A) begin
      head_sat = -ANGLE_W'(8388607) - ANGLE_W'(1);
    end else begin
      head_sat = head_w[ANGLE_W-1:0];
    end
  end

  // Sequencer state and step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state_next != state) begin
        cnt <= '0;
      end else begin
        cnt <= cnt + CNT_W'(1);
      end
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      gyro_weight    <= 16'd32113;
      accel_weight   <= 16'd655;
      rate_offset[0] <= '0;
      rate_offset[1] <= '0;
      rate_offset[2] <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_GYRO_WEIGHT:   gyro_weight    <= cfg_data;
        REG_ACCEL_WEIGHT:  accel_weight   <= cfg_data;
        REG_RATE_OFFSET_X: rate_offset[0] <= cfg_data;
        REG_RATE_OFFSET_Y: rate_offset[1] <= cfg_data;
        REG_RATE_OFFSET_Z: rate_offset[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    logic signed [31:0] sq_a;
    logic signed [31:0] sq_b;
    logic signed [16:0] diff;
    logic signed [33:0] prod;
    logic [32:0]        mag;
    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ys;
    if (ctrl.load) begin
      for (int k = 0; k < 3; k++) begin
        accel[k] <= s_tdata[16*k +: 16];
        rate[k]  <= s_tdata[48 + 16*k +: 16];
      end
      elapsed_ms <= s_tdata[111:96];
      seed       <= s_tuser;
    end
    // Sum of squares feeds the root, shifted up by 32 bits.
    if (ctrl.square) begin
      for (int l = 0; l < 2; l++) begin
        sq_a    = accel[2] * accel[2];
        sq_b    = b_in[l] * b_in[l];
        rad[l]  <= {32'(sq_a) + 32'(sq_b), 32'd0};
        rem[l]  <= '0;
        root[l] <= '0;
      end
    end
    // Two radicand bits per cycle; the last step loads the CORDIC vector.
    if (ctrl.sqrt_step) begin
      for (int l = 0; l < 2; l++) begin
        rad[l]  <= {rad[l][61:0], 2'b00};
        rem[l]  <= rem_next[l];
        root[l] <= root_next[l];
        if (cnt == CNT_W'(SQRT_STEPS - 1)) begin
          cx[l] <= XW'(root_next[l]);
          cy[l] <= XW'(num_in[l]) <<< 16;
          cz[l] <= '0;
        end
      end
    end
    // One CORDIC vectoring step per cycle.
    if (ctrl.cordic_step) begin
      for (int l = 0; l < 2; l++) begin
        xs = cx[l] >>> cnt[4:0];
        ys = cy[l] >>> cnt[4:0];
        if (cy[l] > 0) begin
          cx[l] <= cx[l] + ys;
          cy[l] <= cy[l] - xs;
          cz[l] <= cz[l] + ZW'(atan_deg(cnt[4:0]));
        end else if (cy[l] < 0) begin
          cx[l] <= cx[l] - ys;
          cy[l] <= cy[l] + xs;
          cz[l] <= cz[l] - ZW'(atan_deg(cnt[4:0]));
        end
      end
    end
    if (ctrl.round) begin
      acc_angle[0] <= ang_sat[0];
      acc_angle[1] <= ang_sat[1];
    end
    // Gyro products and divider load, with half the divisor for rounding.
    if (ctrl.gyro) begin
      for (int g = 0; g < 3; g++) begin
        diff    = {rate[g][15], rate[g]} - {rate_offset[g][15], rate_offset[g]};
        prod    = diff * $signed({1'b0, elapsed_ms});
        mag     = prod[33] ? 33'(-prod) : prod[32:0];
        neg[g]  <= prod[33];
        dvd[g]  <= (DW'(mag) << ANGLE_FRAC_BITS) + DW'(GYRO_DIV_HALF);
        drem[g] <= '0;
        quo[g]  <= '0;
      end
    end
    // Restoring division, one quotient bit per cycle.
    if (ctrl.div_step) begin
      for (int g = 0; g < 3; g++) begin
        drem[g] <= div_ge[g] ? div_sh[g] - GYRO_DIV : div_sh[g];
        dvd[g]  <= {dvd[g][DW-2:0], 1'b0};
        quo[g]  <= {quo[g][DW-2:0], div_ge[g]};
      end
    end
    // Load the serial weight multiplier.
    if (ctrl.pred) begin
      for (int l = 0; l < 2; l++) begin
        psh[l]  <= BW'(pred[l]);
        ash[l]  <= BW'(acc_angle[l]);
        bacc[l] <= '0;
      end
      wg <= gyro_weight;
      wa <= accel_weight;
    end
    // One weight bit per cycle for both products.
    if (ctrl.blend_step) begin
      for (int l = 0; l < 2; l++) begin
        bacc[l] <= bacc[l] + (wg[0] ? psh[l] : '0) + (wa[0] ? ash[l] : '0);
        psh[l]  <= psh[l] <<< 1;
        ash[l]  <= ash[l] <<< 1;
      end
      wg <= wg >> 1;
      wa <= wa >> 1;
    end
    if (ctrl.finish) begin
      out_data[103:72] <= {acc_angle[1], acc_angle[0]};
      if (seed) begin
        out_data[71:0] <= {ANGLE_W'(0), ANGLE_W'(acc_angle[1]), ANGLE_W'(acc_angle[0])};
      end else begin
        out_data[71:0] <= {head_sat, blend_sat[1], blend_sat[0]};
      end
    end
  end

  // Filter state and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      tilt[0]  <= '0;
      tilt[1]  <= '0;
      tilt[2]  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (ctrl.finish) begin
        m_tvalid <= 1'b1;
        if (seed) begin
          tilt[0] <= ANGLE_W'(acc_angle[0]);
          tilt[1] <= ANGLE_W'(acc_angle[1]);
          tilt[2] <= '0;
        end else begin
          tilt[0] <= blend_sat[0];
          tilt[1] <= blend_sat[1];
          tilt[2] <= head_sat;
        end
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire
